FILE: src/ssr_pkg.sv
// shared types and constants of the stream substring replacer
package ssr_pkg;

    localparam int WIN_DEPTH = 8;

    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic acc_more;
        logic step_more;
    } t_status;

endpackage

FILE: src/ssr_ctrl.sv
// controller state machine of the stream substring replacer
module ssr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  ssr_pkg::t_status i_sts,
    output logic            o_s_tready,
    output ssr_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_s_tready = (r_state == ST_IDLE) && i_sts.out_free;
        o_cmd.accept = o_s_tready && i_s_tvalid;
        o_cmd.step = (r_state == ST_BUSY) && i_sts.out_free;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_sts.acc_more) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (o_cmd.step && !i_sts.step_more) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/ssr_datapath.sv
// window, configuration registers and output register of the substring replacer
module ssr_datapath #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssr_pkg::t_cmd     i_cmd,
    output ssr_pkg::t_status  o_sts,
    input  logic [7:0]        i_in_byte,
    input  logic              i_eos,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_valid,
    output logic              o_last
);

    localparam int D = ssr_pkg::WIN_DEPTH;
    localparam logic [3:0] LP_PCAP = (MAX_PATTERN < 8) ? 4'(MAX_PATTERN) : 4'd8;
    localparam logic [3:0] LP_RCAP = (MAX_REPLACEMENT < 8) ? 4'(MAX_REPLACEMENT) : 4'd8;

    logic [63:0] r_pat;
    logic [63:0] r_rep;
    logic [3:0]  r_plen_reg;
    logic [3:0]  r_rlen_reg;

    logic [7:0]  r_win [D];
    logic [3:0]  r_wc;
    logic [2:0]  r_rep_left;
    logic [2:0]  r_rep_idx;
    logic        r_eos;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_bval;
    logic        r_out_last;

    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [3:0]  wc_c;
    logic [3:0]  wc_i;
    logic [7:0]  win_i [D];
    logic        match;
    logic        do_pop;
    logic        do_match;

    logic [7:0]  a_win [D];
    logic [3:0]  a_wc;
    logic [2:0]  a_rep_left;
    logic [2:0]  a_rep_idx;
    logic        a_emit;
    logic [7:0]  a_byte;
    logic        a_bval;
    logic        a_last;

    logic [7:0]  b_win [D];
    logic [3:0]  b_wc;
    logic [2:0]  b_rep_left;
    logic [2:0]  b_rep_idx;
    logic [7:0]  b_byte;
    logic        b_last;

    logic        acc_more;
    logic        step_more;
    logic        out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat      <= '0;
            r_plen_reg <= 4'd1;
            r_rep      <= '0;
            r_rlen_reg <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ssr_pkg::CFG_PATTERN_BYTES:      r_pat      <= i_cfg_data;
                ssr_pkg::CFG_PATTERN_LENGTH:     r_plen_reg <= i_cfg_data[3:0];
                ssr_pkg::CFG_REPLACEMENT_BYTES:  r_rep      <= i_cfg_data;
                ssr_pkg::CFG_REPLACEMENT_LENGTH: r_rlen_reg <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective lengths
    always_comb begin
        if (r_plen_reg == 4'd0) begin
            plen = 4'd1;
        end else if (r_plen_reg > 4'd8) begin
            plen = 4'd8;
        end else begin
            plen = r_plen_reg;
        end
        if (plen > LP_PCAP) begin
            plen = LP_PCAP;
        end
        rlen = (r_rlen_reg > 4'd8) ? 4'd8 : r_rlen_reg;
        if (rlen > LP_RCAP) begin
            rlen = LP_RCAP;
        end
    end

    // insert the new byte and compare
    always_comb begin
        wc_c = (r_wc > 4'd7) ? 4'd7 : r_wc;
        wc_i = wc_c + 4'd1;
        match = 1'b1;
        for (int k = 0; k < D; k++) begin
            win_i[k] = (wc_c[2:0] == 3'(k)) ? i_in_byte : r_win[k];
            if ((4'(k) < plen) && (win_i[k] != r_pat[8*k +: 8])) begin
                match = 1'b0;
            end
        end
        do_match = (wc_i == plen) && match;
        do_pop   = ((wc_i == plen) && !match) || (wc_i > plen);
    end

    // first result of an accepted transfer
    always_comb begin
        a_win      = win_i;
        a_wc       = wc_i;
        a_rep_left = '0;
        a_rep_idx  = '0;
        a_emit     = 1'b0;
        a_byte     = win_i[0];
        a_bval     = 1'b1;
        if (do_pop || (!do_match && i_eos)) begin
            a_emit = 1'b1;
            for (int k = 0; k < D; k++) begin
                a_win[k] = (k < D - 1) ? win_i[(k + 1) % D] : 8'd0;
            end
            a_wc = wc_i - 4'd1;
        end else if (do_match) begin
            for (int k = 0; k < D; k++) begin
                a_win[k] = 8'd0;
            end
            a_wc = 4'd0;
            if (rlen != 4'd0) begin
                a_emit     = 1'b1;
                a_byte     = r_rep[7:0];
                a_rep_left = 3'(rlen - 4'd1);
                a_rep_idx  = 3'd1;
            end else if (i_eos) begin
                a_emit = 1'b1;
                a_byte = 8'd0;
                a_bval = 1'b0;
            end
        end
        a_last   = i_eos && (a_rep_left == 3'd0) && (a_wc == 4'd0);
        acc_more = (a_rep_left != 3'd0) || (i_eos && (a_wc != 4'd0));
    end

    // one further result per step: replacement bytes, then the flush
    always_comb begin
        b_win      = r_win;
        b_wc       = r_wc;
        b_rep_left = r_rep_left;
        b_rep_idx  = r_rep_idx;
        if (r_rep_left != 3'd0) begin
            b_byte     = r_rep[{r_rep_idx, 3'b000} +: 8];
            b_rep_left = r_rep_left - 3'd1;
            b_rep_idx  = r_rep_idx + 3'd1;
        end else begin
            b_byte = r_win[0];
            for (int k = 0; k < D; k++) begin
                b_win[k] = (k < D - 1) ? r_win[(k + 1) % D] : 8'd0;
            end
            b_wc = r_wc - 4'd1;
        end
        b_last    = r_eos && (b_rep_left == 3'd0) && (b_wc == 4'd0);
        step_more = (b_rep_left != 3'd0) || (r_eos && (b_wc != 4'd0));
        out_free  = !r_out_valid || i_m_tready;
    end

    assign o_sts = '{out_free: out_free, acc_more: acc_more, step_more: step_more};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D; k++) begin
                r_win[k] <= 8'd0;
            end
            r_wc       <= '0;
            r_rep_left <= '0;
            r_rep_idx  <= '0;
            r_eos      <= 1'b0;
        end else if (i_cmd.accept) begin
            r_win      <= a_win;
            r_wc       <= a_wc;
            r_rep_left <= a_rep_left;
            r_rep_idx  <= a_rep_idx;
            r_eos      <= i_eos && acc_more;
        end else if (i_cmd.step) begin
            r_win      <= b_win;
            r_wc       <= b_wc;
            r_rep_left <= b_rep_left;
            r_rep_idx  <= b_rep_idx;
            r_eos      <= r_eos && step_more;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.accept && a_emit) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= a_byte;
            r_out_bval  <= a_bval;
            r_out_last  <= a_last;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= b_byte;
            r_out_bval  <= 1'b1;
            r_out_last  <= b_last;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_out_bval;
    assign o_last       = r_out_last;

    a_wc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= 4'd7)
        else $error("window count out of range");

    a_step_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> ((r_rep_left != 3'd0) || (r_eos && (r_wc != 4'd0))))
        else $error("step with nothing pending");

    a_accept_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> ((r_rep_left == 3'd0) && !r_eos && !i_cmd.step))
        else $error("transfer accepted while results pending");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_bval) |-> r_out_last)
        else $error("bare marker without last");

endmodule

FILE: src/stream_substring_replacer.sv
// top level of the stream substring replacer
// a result is written straight into the output register by the transfer that causes it
// throughput: one input transfer per cycle unless results are pending or output stalls
// a match with a replacement of n bytes holds the input until the other n - 1 bytes are out
// end of stream holds the input until the window bytes after the first result are flushed
// reset clears the window and loads the default pattern and replacement settings
module stream_substring_replacer #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast,   // last
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_data
);

    ssr_pkg::t_cmd    cmd;
    ssr_pkg::t_status sts;

    ssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    ssr_datapath #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_byte    (s_axis_tdata),
        .i_eos        (s_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_out_byte   (m_axis_tdata),
        .o_byte_valid (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

endmodule

FILE: test/tb_top.sv
// testbench of stream_substring_replacer: random byte streams checked against a replacement predictor
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_text_byte;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_out_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // in_byte
    logic        s_axis_tlast = 1'b0;   // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // out_byte
    logic        m_axis_tuser;          // byte_valid
    logic        m_axis_tlast;          // last
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [63:0] i_cfg_data = '0;

    stream_substring_replacer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies and window state of the predictor
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len_reg = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len_reg = 4'd0;
    logic [7:0]  win [ssr_pkg::WIN_DEPTH];
    int          win_cnt = 0;

    t_text_byte text_q [$];
    t_out_byte  want_q [$];

    int  errors = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_hits = 0;
    int  n_streams = 0;
    int  src_gap = 0;
    int  sink_hold = 0;
    bit  src_steady = 1'b0;
    bit  sink_steady = 1'b0;
    bit  long_hold_req = 1'b0;
    t_text_byte nxt;
    t_out_byte  want;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_pat_len();
        if (pat_len_reg == 0)
            return 1;
        if (pat_len_reg > 8)
            return 8;
        return pat_len_reg;
    endfunction

    function automatic void expect_byte(input logic [7:0] d, input logic v);
        t_out_byte o;
        o.data  = d;
        o.valid = v;
        o.last  = 1'b0;
        want_q.insert(want_q.size(), o);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < ssr_pkg::WIN_DEPTH; i++)
            win[i] = 8'h00;
        win_cnt = 0;
    endfunction

    function automatic void pass_oldest();
        expect_byte(win[0], 1'b1);
        for (int i = 0; i < ssr_pkg::WIN_DEPTH - 1; i++)
            win[i] = win[i + 1];
        win[ssr_pkg::WIN_DEPTH - 1] = 8'h00;
        if (win_cnt > 0)
            win_cnt--;
    endfunction

    // expected output bytes for one accepted input byte
    function automatic void replace_step(input logic [7:0] b, input logic eos);
        int   plen;
        int   rlen;
        int   start;
        logic hit;
        plen = eff_pat_len();
        rlen = (rep_len_reg > 8) ? 8 : rep_len_reg;
        start = want_q.size();
        if (win_cnt > 7)
            win_cnt = 7;
        win[win_cnt] = b;
        win_cnt++;
        if (win_cnt == plen) begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++)
                if (win[i] != pat_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                n_hits++;
                for (int i = 0; i < rlen; i++)
                    expect_byte(rep_bytes[8*i +: 8], 1'b1);
                clear_window();
            end else begin
                pass_oldest();
            end
        end else if (win_cnt > plen) begin
            pass_oldest();
        end
        if (eos) begin
            for (int i = 0; i < win_cnt && i < ssr_pkg::WIN_DEPTH; i++)
                expect_byte(win[i], 1'b1);
            if (want_q.size() == start)
                expect_byte(8'h00, 1'b0);
            want_q[want_q.size() - 1].last = 1'b1;
            clear_window();
            n_streams++;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                replace_step(s_axis_tdata, s_axis_tlast);
                n_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (text_q.size() > 0) begin
                    nxt = text_q.pop_front();
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.eos;
                    s_axis_tvalid <= 1'b1;
                    if (!src_steady)
                        src_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_out++;
                if (want_q.size() == 0) begin
                    errors++;
                    if (errors < 40)
                        $display("%0t unexpected transfer: got data %02h user %b last %b",
                                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = want_q.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tuser !== want.valid ||
                        m_axis_tlast !== want.last) begin
                        errors++;
                        if (errors < 40)
                            $display("%0t mismatch: expected %02h/%b/%b got %02h/%b/%b",
                                     $time, want.data, want.valid, want.last,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                sink_hold = 250;
                m_axis_tready <= 1'b0;
            end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
                sink_hold = pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input ssr_pkg::t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            ssr_pkg::CFG_PATTERN_BYTES:      pat_bytes = val;
            ssr_pkg::CFG_PATTERN_LENGTH:     pat_len_reg = val[3:0];
            ssr_pkg::CFG_REPLACEMENT_BYTES:  rep_bytes = val;
            ssr_pkg::CFG_REPLACEMENT_LENGTH: rep_len_reg = val[3:0];
            default: ;
        endcase
    endtask

    task automatic reg_write_end();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] pat, input logic [3:0] plen,
                              input logic [63:0] rep, input logic [3:0] rlen);
        reg_write(ssr_pkg::CFG_PATTERN_BYTES, pat);
        reg_write(ssr_pkg::CFG_PATTERN_LENGTH, {60'd0, plen});
        reg_write(ssr_pkg::CFG_REPLACEMENT_BYTES, rep);
        reg_write(ssr_pkg::CFG_REPLACEMENT_LENGTH, {60'd0, rlen});
        reg_write_end();
    endtask

    // waits until the sender has sent everything and every result is back, then lets the pipeline settle
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (text_q.size() > 0 || s_axis_tvalid || want_q.size() > 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic void add_byte(input logic [7:0] b, input logic eos);
        t_text_byte t;
        t.data = b;
        t.eos  = eos;
        text_q.insert(text_q.size(), t);
    endfunction

    // text with full matches, broken prefixes, near misses and stray stream ends
    task automatic gen_text(input int count);
        int k;
        int r;
        int plen;
        int part;
        plen = eff_pat_len();
        k = 0;
        while (k < count) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                for (int j = 0; j < plen; j++)
                    add_byte(pat_bytes[8*j +: 8], $urandom_range(0, 29) == 0);
                k += plen;
            end else if (r < 6 && plen > 1) begin
                part = $urandom_range(1, plen - 1);
                for (int j = 0; j < part; j++)
                    add_byte(pat_bytes[8*j +: 8], 1'b0);
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
                k += part + 1;
            end else begin
                if ($urandom_range(0, 1))
                    add_byte(pat_bytes[8*$urandom_range(0, plen - 1) +: 8],
                             $urandom_range(0, 29) == 0);
                else
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
                k++;
            end
        end
        text_q[text_q.size() - 1].eos = 1'b1;
    endtask

    initial begin
        int plen;
        int rlen;
        clear_window();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings remove zero bytes; a lone removed byte leaves a bare end marker
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'h00, 1'b1);
        wait_idle();

        // zero pattern length acts as one, oversized replacement length saturates
        set_config(64'h41, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b1);
        wait_idle();

        // oversized pattern length saturates; match on the last byte, then a plain flush
        set_config(64'hFF00_FF00_A55A_0F01, 4'd15, 64'h0, 4'd8);
        for (int j = 0; j < 8; j++)
            add_byte(pat_bytes[8*j +: 8], j == 7);
        add_byte(8'h01, 1'b0);
        add_byte(8'h0F, 1'b0);
        add_byte(8'h77, 1'b1);
        wait_idle();

        // pattern shortened while bytes are pending
        set_config(64'hFF00_FF00_A55A_0F01, 4'd4, 64'h0, 4'd0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h0F, 1'b0);
        add_byte(8'h5A, 1'b0);
        wait_idle();
        reg_write(ssr_pkg::CFG_PATTERN_LENGTH, 64'd2);
        reg_write_end();
        add_byte(8'hA5, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h0F, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if ($urandom_range(0, 3) == 0)
                plen = $urandom_range(0, 15);
            else
                plen = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0)
                rlen = $urandom_range(0, 15);
            else
                rlen = $urandom_range(0, 8);
            if (ph == 0) begin
                plen = 1;
                rlen = 8;
            end else if (ph == 1) begin
                plen = 8;
                rlen = 0;
            end else if (ph == 3) begin
                plen = 2;
                rlen = 8;
            end
            set_config({$urandom, $urandom}, 4'(plen), {$urandom, $urandom}, 4'(rlen));
            src_steady  = (ph == 2 || ph == 3);
            sink_steady = (ph == 2);
            if (ph == 3)
                long_hold_req = 1'b1;
            gen_text(55);
            wait_idle();
        end

        $display("covered %0d input transfers over %0d streams, %0d output transfers, %0d matches",
                 n_in, n_streams, n_out, n_hits);
        if (want_q.size() > 0) begin
            errors++;
            $display("%0t %0d expected results never arrived", $time, want_q.size());
        end
        if (errors == 0)
            $display("PASS stream_substring_replacer");
        else
            $display("FAIL stream_substring_replacer");
        $finish;
    end

    initial begin
        #10000000;
        $display("timeout with %0d results outstanding", want_q.size());
        $display("FAIL stream_substring_replacer");
        $finish;
    end

endmodule
